[rtl/kpl_pkg.sv]
// Package for the keystroke password lockout block.
// Holds sizes, key and result codes, and the structs passed between blocks.
// No dependencies.
`default_nettype none

package kpl_pkg;

    localparam int ENTRY_BYTES = 16;
    localparam int BUF_DEPTH   = 15;
    localparam int PW_BYTES    = 15;
    localparam int KEY_W       = 8;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 4;
    localparam int WORD_W      = 64;
    localparam int IDX_W       = 2;

    localparam int ENTRY_MAX_INT = (ENTRY_BYTES - 1 < BUF_DEPTH) ? ENTRY_BYTES - 1 : BUF_DEPTH;
    localparam logic [LEN_W-1:0] ENTRY_LIMIT = LEN_W'(ENTRY_MAX_INT);

    localparam logic [KEY_W-1:0] KEY_NUL = 8'd0;
    localparam logic [KEY_W-1:0] KEY_BS  = 8'd8;
    localparam logic [KEY_W-1:0] KEY_LF  = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR  = 8'd13;

    localparam logic [IDX_W-1:0] REG_PW_LOW   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PW_HIGH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_ATT  = 2'd2;

    localparam logic [WORD_W-1:0] PW_LOW_RESET  = 64'd495791400296;
    localparam logic [WORD_W-1:0] PW_HIGH_RESET = 64'd0;
    localparam logic [CNT_W-1:0]  MAX_ATT_RESET = 4'd3;
    localparam logic [CNT_W-1:0]  FAIL_SAT      = 4'd15;

    localparam logic [1:0] MODE_LOGIN  = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_LOCKED = 2'd2;
    localparam logic [1:0] MODE_HALTED = 2'd3;

    typedef enum logic [1:0] {
        ECHO_NONE      = 2'd0,
        ECHO_NEWLINE   = 2'd1,
        ECHO_BACKSPACE = 2'd2,
        ECHO_ASTERISK  = 2'd3
    } echo_t;

    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_LOGIN_OK       = 3'd1,
        EV_LOGIN_FAIL     = 3'd2,
        EV_HALTED         = 3'd3,
        EV_SESSION_LOCKED = 3'd4,
        EV_UNLOCKED       = 3'd5,
        EV_UNLOCK_FAIL    = 3'd6
    } event_t;

    typedef logic [PW_BYTES-1:0][KEY_W-1:0] pw_bytes_t;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_code;
    } key_item_t;

    typedef struct packed {
        logic             clear;
        logic             pop;
        logic             push;
        logic [KEY_W-1:0] key;
    } entry_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic             match;
    } entry_stat_t;

    typedef struct packed {
        echo_t            echo_code;
        event_t           event_res;
        logic [1:0]       mode;
        logic [LEN_W-1:0] entered_length;
        logic [CNT_W-1:0] failure_count;
    } result_t;

endpackage

`default_nettype wire

[rtl/kpl_if.sv]
// Handshake channels of the keystroke password lockout block.
// Key item channel and result item channel; depends on kpl_pkg.
`default_nettype none

interface kpl_key_if;
    import kpl_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output req_type, output key_code, input ready);
    modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

interface kpl_res_if;
    import kpl_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       echo_code;
    logic [2:0]       event_res;
    logic [1:0]       mode;
    logic [LEN_W-1:0] entered_length;
    logic [CNT_W-1:0] failure_count;

    modport source (output valid, output echo_code, output event_res, output mode,
                    output entered_length, output failure_count, input ready);
    modport sink   (input valid, input echo_code, input event_res, input mode,
                    input entered_length, input failure_count, output ready);
endinterface

`default_nettype wire

[rtl/kpl_cfg_regs.sv]
// Configuration registers: password words and attempt limit.
// Derives password bytes, password length and the effective limit; uses kpl_pkg.
`default_nettype none

module kpl_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [kpl_pkg::IDX_W-1:0]    wr_index,
    input  logic [kpl_pkg::WORD_W-1:0]   wr_data,
    output kpl_pkg::pw_bytes_t           pw_bytes,
    output logic [kpl_pkg::LEN_W-1:0]    pw_len,
    output logic [kpl_pkg::CNT_W-1:0]    limit
);
    import kpl_pkg::*;

    logic [WORD_W-1:0] pw_low_reg;
    logic [WORD_W-1:0] pw_high_reg;
    logic [CNT_W-1:0]  max_att_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_low_reg  <= PW_LOW_RESET;
            pw_high_reg <= PW_HIGH_RESET;
            max_att_reg <= MAX_ATT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PW_LOW:  pw_low_reg  <= wr_data;
                REG_PW_HIGH: pw_high_reg <= wr_data;
                REG_MAX_ATT: max_att_reg <= wr_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < PW_BYTES; i++)
        begin
            if (i < 8)
                pw_bytes[i] = pw_low_reg[8*i +: 8];
            else
                pw_bytes[i] = pw_high_reg[8*(i-8) +: 8];
        end
    end

    // first zero byte ends the password
    always_comb
    begin
        pw_len = LEN_W'(PW_BYTES);
        for (int i = PW_BYTES - 1; i >= 0; i--)
        begin
            if (pw_bytes[i] == KEY_NUL)
                pw_len = LEN_W'(i);
        end
    end

    assign limit = (max_att_reg == '0) ? CNT_W'(1) : max_att_reg;

endmodule

`default_nettype wire

[rtl/kpl_entry_buf.sv]
// Entry buffer: held characters, fill count and the line compare.
// Driven by entry commands from kpl_access_ctrl; uses kpl_pkg.
`default_nettype none

module kpl_entry_buf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kpl_pkg::entry_cmd_t          cmd,
    input  kpl_pkg::pw_bytes_t           pw_bytes,
    input  logic [kpl_pkg::LEN_W-1:0]    pw_len,
    output kpl_pkg::entry_stat_t         stat
);
    import kpl_pkg::*;

    logic [KEY_W-1:0] ent_reg [BUF_DEPTH];
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             match;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.pop)
            count_next = count_reg - LEN_W'(1);
        else if (cmd.push)
            count_next = count_reg + LEN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            ent_reg[count_reg] <= cmd.key;
    end

    // compare held characters only
    always_comb
    begin
        match = (count_reg == pw_len);
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (LEN_W'(i) < count_reg && ent_reg[i] != pw_bytes[i])
                match = 1'b0;
        end
    end

    assign stat.count = count_reg;
    assign stat.match = match;

endmodule

`default_nettype wire

[rtl/kpl_access_ctrl.sv]
// Access control: mode state machine, failure counter and result register.
// Issues entry commands to kpl_entry_buf; uses kpl_pkg.
`default_nettype none

module kpl_access_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  kpl_pkg::key_item_t           item,
    input  kpl_pkg::entry_stat_t         stat,
    input  logic [kpl_pkg::CNT_W-1:0]    limit,
    input  logic                         res_ready,
    output kpl_pkg::entry_cmd_t          cmd,
    output logic                         res_valid,
    output kpl_pkg::result_t             res
);
    import kpl_pkg::*;

    typedef enum logic [1:0] {
        ST_LOGIN  = MODE_LOGIN,
        ST_OPEN   = MODE_OPEN,
        ST_LOCKED = MODE_LOCKED,
        ST_HALTED = MODE_HALTED
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] fail_reg;
    logic [CNT_W-1:0] fail_next;
    logic [CNT_W-1:0] fail_inc;
    logic             res_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    entry_cmd_t       cmd_raw;
    logic             entry_mode;

    assign entry_mode = (state_reg == ST_LOGIN) || (state_reg == ST_LOCKED);
    assign fail_inc   = (fail_reg == FAIL_SAT) ? FAIL_SAT : fail_reg + CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        fail_next       = fail_reg;
        cmd_raw         = '0;
        cmd_raw.key     = item.key_code;
        res_next.echo_code      = ECHO_NONE;
        res_next.event_res      = EV_NONE;
        res_next.entered_length = stat.count;

        if (item.req_type)
        begin
            if (state_reg == ST_OPEN)
            begin
                state_next              = ST_LOCKED;
                cmd_raw.clear           = 1'b1;
                res_next.entered_length = '0;
                res_next.event_res      = EV_SESSION_LOCKED;
            end
        end
        else if (entry_mode && item.key_code != KEY_NUL)
        begin
            unique case (item.key_code) inside
                KEY_LF, KEY_CR:
                begin
                    cmd_raw.clear           = 1'b1;
                    res_next.entered_length = '0;
                    res_next.echo_code      = ECHO_NEWLINE;
                    if (state_reg == ST_LOGIN)
                    begin
                        if (stat.match)
                        begin
                            state_next         = ST_OPEN;
                            res_next.event_res = EV_LOGIN_OK;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                            if (fail_inc >= limit)
                            begin
                                state_next         = ST_HALTED;
                                res_next.event_res = EV_HALTED;
                            end
                            else
                                res_next.event_res = EV_LOGIN_FAIL;
                        end
                    end
                    else if (stat.match)
                    begin
                        state_next         = ST_OPEN;
                        res_next.event_res = EV_UNLOCKED;
                    end
                    else
                        res_next.event_res = EV_UNLOCK_FAIL;
                end
                KEY_BS:
                begin
                    if (stat.count != '0)
                    begin
                        cmd_raw.pop             = 1'b1;
                        res_next.entered_length = stat.count - LEN_W'(1);
                        res_next.echo_code      = ECHO_BACKSPACE;
                    end
                end
                default:
                begin
                    if (stat.count < ENTRY_LIMIT)
                    begin
                        cmd_raw.push            = 1'b1;
                        res_next.entered_length = stat.count + LEN_W'(1);
                        res_next.echo_code      = ECHO_ASTERISK;
                    end
                end
            endcase
        end

        res_next.mode          = state_next;
        res_next.failure_count = fail_next;
    end

    always_comb
    begin
        cmd       = cmd_raw;
        cmd.clear = adv & cmd_raw.clear;
        cmd.pop   = adv & cmd_raw.pop;
        cmd.push  = adv & cmd_raw.push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOGIN;
            fail_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (adv)
        begin
            state_reg     <= state_next;
            fail_reg      <= fail_next;
            res_valid_reg <= 1'b1;
            res_reg       <= res_next;
        end
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/keystroke_password_lockout.sv]
// Top level of the keystroke password lockout block.
// Depends on kpl_pkg, kpl_if, kpl_cfg_regs, kpl_entry_buf, kpl_access_ctrl.
//
//   channel   dir  handshake       payload
//   keys      in   valid / ready   req_type, key_code
//   results   out  valid / ready   echo_code, event_res, mode, entered_length, failure_count
//   config    in   wr_en           wr_index, wr_data
//
// The path holds two registers: input register, then result register.
// One item per cycle unless results stall; mode and entry update with the result register.
// A stalled result holds in the result register while one more item waits
// in the input register. Reset clears the count, failures, mode and valids;
// the entry characters are left as they are.
`default_nettype none

module keystroke_password_lockout (
    input  logic                         clk,
    input  logic                         rst_n,
    kpl_key_if.sink                      keys,
    kpl_res_if.source                    results,
    input  logic                         wr_en,
    input  logic [kpl_pkg::IDX_W-1:0]    wr_index,
    input  logic [kpl_pkg::WORD_W-1:0]   wr_data
);
    import kpl_pkg::*;

    logic          s1_valid_reg;
    key_item_t     s1_item_reg;
    logic          slot_free;
    logic          adv;
    logic          res_valid;
    result_t       res;
    entry_cmd_t    cmd;
    entry_stat_t   stat;
    pw_bytes_t     pw_bytes;
    logic [LEN_W-1:0] pw_len;
    logic [CNT_W-1:0] limit;

    assign slot_free  = !res_valid || results.ready;
    assign adv        = s1_valid_reg && slot_free;
    assign keys.ready = !s1_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (keys.ready)
            s1_valid_reg <= keys.valid;
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            s1_item_reg.req_type <= keys.req_type;
            s1_item_reg.key_code <= keys.key_code;
        end
    end

    kpl_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pw_bytes (pw_bytes),
        .pw_len   (pw_len),
        .limit    (limit)
    );

    kpl_entry_buf u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pw_bytes (pw_bytes),
        .pw_len   (pw_len),
        .stat     (stat)
    );

    kpl_access_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .item      (s1_item_reg),
        .stat      (stat),
        .limit     (limit),
        .res_ready (results.ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    assign results.valid          = res_valid;
    assign results.echo_code      = res.echo_code;
    assign results.event_res      = res.event_res;
    assign results.mode           = res.mode;
    assign results.entered_length = res.entered_length;
    assign results.failure_count  = res.failure_count;

endmodule

`default_nettype wire

[rtl/kpl_checker.sv]
// Port-level checks for the keystroke password lockout block.
// Bound to keystroke_password_lockout; uses kpl_pkg.
`default_nettype none

module kpl_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_valid,
    input  logic                         res_ready,
    input  logic [1:0]                   echo_code,
    input  logic [2:0]                   event_res,
    input  logic [1:0]                   mode,
    input  logic [kpl_pkg::LEN_W-1:0]    entered_length,
    input  logic [kpl_pkg::CNT_W-1:0]    failure_count
);
    import kpl_pkg::*;

    logic halted_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            halted_seen_reg <= 1'b0;
        else if (res_valid && res_ready && mode == MODE_HALTED)
            halted_seen_reg <= 1'b1;
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(echo_code) && $stable(event_res)
            && $stable(mode) && $stable(entered_length) && $stable(failure_count))
        else $error("result changed while stalled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_seen_reg && res_valid |-> mode == MODE_HALTED && event_res == EV_NONE
            && echo_code == ECHO_NONE)
        else $error("activity after halt");

    a_submit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && echo_code == ECHO_NEWLINE |-> entered_length == '0 && event_res != EV_NONE)
        else $error("submit left entry or gave no event");

    a_open_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res == EV_LOGIN_OK || event_res == EV_UNLOCKED)
            |-> mode == MODE_OPEN && entered_length == '0)
        else $error("match did not open access");

endmodule

bind keystroke_password_lockout kpl_checker u_kpl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .echo_code      (results.echo_code),
    .event_res      (results.event_res),
    .mode           (results.mode),
    .entered_length (results.entered_length),
    .failure_count  (results.failure_count)
);

`default_nettype wire
